[sv/canopen_led_indicator_defines.svh]
// assertion macros shared by the indicator blocks
`ifndef CANOPEN_LED_INDICATOR_DEFINES_SVH
`define CANOPEN_LED_INDICATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/coled_pkg.sv]
package coled_pkg;

    localparam int unsigned TICK_US_DEF = 50000;

    localparam int unsigned ELAPSED_W = 20;
    localparam int unsigned REM_W     = 16;
    localparam int unsigned ACC_W     = 21;
    localparam int unsigned NSTATE_W  = 3;
    localparam int unsigned PAT_W     = 8;
    localparam int unsigned FLASH_W   = 4;
    localparam int unsigned FLASH_NUM = 4;

    // bitmap layout
    localparam int unsigned BIT_FLICKER = 0;
    localparam int unsigned BIT_BLINK   = 1;
    localparam int unsigned BIT_FLASH1  = 2;
    localparam int unsigned BIT_FLASH2  = 3;
    localparam int unsigned BIT_FLASH3  = 4;
    localparam int unsigned BIT_FLASH4  = 5;
    localparam int unsigned BIT_LED     = 7;

    // bits carried over on a tick that is not a quarter boundary
    localparam logic [PAT_W-1:0] KEEP_MASK = 8'h7E;

    localparam logic [NSTATE_W-1:0] NODE_INIT    = 3'd0;
    localparam logic [NSTATE_W-1:0] NODE_PREOP   = 3'd1;
    localparam logic [NSTATE_W-1:0] NODE_OPER    = 3'd2;
    localparam logic [NSTATE_W-1:0] NODE_STOPPED = 3'd3;

    typedef struct packed {
        logic [NSTATE_W-1:0] node_state;
        logic                lss_config;
        logic                bus_off;
        logic                bus_warning;
        logic                rpdo_error;
        logic                sync_error;
        logic                heartbeat_error;
        logic                other_error;
        logic                firmware_download;
    } flags_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic tick_due;
    } status_t;

    typedef struct packed {
        logic [FLASH_W-1:0] cnt;
        logic               red;
        logic               grn;
    } flash_res_t;

    // one step of an n-flash counter: odd counts light red, even counts green,
    // wrap to zero when the period is reached
    function automatic flash_res_t flash_step(input logic [FLASH_W-1:0] cnt,
                                              input logic [FLASH_W-1:0] lim,
                                              input logic [FLASH_W-1:0] period);
        flash_res_t         r;
        logic [FLASH_W-1:0] c;
        c     = cnt + 4'd1;
        r.cnt = c;
        r.red = 1'b0;
        r.grn = 1'b0;
        if (c != 4'd0 && c <= lim)
        begin
            r.red = c[0];
            r.grn = !c[0];
        end
        else if (c == period)
        begin
            r.cnt = 4'd0;
        end
        return r;
    endfunction

endpackage

[sv/coled_dp.sv]
`include "canopen_led_indicator_defines.svh"

module coled_dp #(
    parameter int unsigned TICK_US = coled_pkg::TICK_US_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [coled_pkg::ELAPSED_W-1:0]     elapsed_us,
    input  coled_pkg::flags_t                   flags_in,
    input  coled_pkg::cmd_t                     cmd,
    output coled_pkg::status_t                  status,
    output logic [coled_pkg::PAT_W-1:0]         red_pattern,
    output logic [coled_pkg::PAT_W-1:0]         green_pattern,
    output logic [coled_pkg::REM_W-1:0]         time_to_next_us
);

    logic [coled_pkg::ACC_W-1:0]   acc_reg;
    logic [coled_pkg::REM_W-1:0]   rem_reg;
    logic [coled_pkg::REM_W-1:0]   time_next_reg;
    logic [1:0]                    quarter_reg;
    logic [coled_pkg::FLASH_W-1:0] flash_cnt_reg [coled_pkg::FLASH_NUM];
    logic [coled_pkg::FLASH_W-1:0] flash_cnt_next [coled_pkg::FLASH_NUM];
    logic [coled_pkg::PAT_W-1:0]   red_bits_reg;
    logic [coled_pkg::PAT_W-1:0]   green_bits_reg;
    logic [coled_pkg::PAT_W-1:0]   work_rd_reg;
    logic [coled_pkg::PAT_W-1:0]   work_gr_reg;
    logic [coled_pkg::PAT_W-1:0]   tick_rd;
    logic [coled_pkg::PAT_W-1:0]   tick_gr;
    logic                          tick_seen_reg;
    coled_pkg::flags_t             flags_reg;
    coled_pkg::flash_res_t         flash_res [coled_pkg::FLASH_NUM];
    logic                          red_co;
    logic                          green_co;

    assign status.tick_due = (acc_reg >= coled_pkg::ACC_W'(TICK_US));

    always_comb
    begin
        for (int i = 0; i < coled_pkg::FLASH_NUM; i++)
        begin
            flash_res[i] = coled_pkg::flash_step(flash_cnt_reg[i],
                                                 coled_pkg::FLASH_W'(2 * i + 2),
                                                 coled_pkg::FLASH_W'(2 * i + 6));
        end
    end

    // working bitmaps of one tick, built from the stored bitmaps and the flash counters
    always_comb
    begin
        tick_rd = '0;
        tick_gr = '0;
        for (int i = 0; i < coled_pkg::FLASH_NUM; i++)
        begin
            flash_cnt_next[i] = flash_cnt_reg[i];
        end
        if (quarter_reg == 2'd3)
        begin
            if (!red_bits_reg[coled_pkg::BIT_BLINK])
                tick_rd[coled_pkg::BIT_BLINK] = 1'b1;
            else
                tick_gr[coled_pkg::BIT_BLINK] = 1'b1;
            for (int i = 0; i < coled_pkg::FLASH_NUM; i++)
            begin
                flash_cnt_next[i]                  = flash_res[i].cnt;
                tick_rd[coled_pkg::BIT_FLASH1 + i] = flash_res[i].red;
                tick_gr[coled_pkg::BIT_FLASH1 + i] = flash_res[i].grn;
            end
        end
        else
        begin
            tick_rd = red_bits_reg & coled_pkg::KEEP_MASK;
            tick_gr = green_bits_reg & coled_pkg::KEEP_MASK;
        end
        if (!red_bits_reg[coled_pkg::BIT_FLICKER])
            tick_rd[coled_pkg::BIT_FLICKER] = 1'b1;
        else
            tick_gr[coled_pkg::BIT_FLICKER] = 1'b1;
    end

    // led selection by fixed priority
    always_comb
    begin
        if (flags_reg.bus_off)
            red_co = 1'b1;
        else if (flags_reg.node_state == coled_pkg::NODE_INIT)
            red_co = work_rd_reg[coled_pkg::BIT_FLICKER];
        else if (flags_reg.rpdo_error)
            red_co = work_rd_reg[coled_pkg::BIT_FLASH4];
        else if (flags_reg.sync_error)
            red_co = work_rd_reg[coled_pkg::BIT_FLASH3];
        else if (flags_reg.heartbeat_error)
            red_co = work_rd_reg[coled_pkg::BIT_FLASH2];
        else if (flags_reg.bus_warning)
            red_co = work_rd_reg[coled_pkg::BIT_FLASH1];
        else if (flags_reg.other_error)
            red_co = work_rd_reg[coled_pkg::BIT_BLINK];
        else
            red_co = 1'b0;

        if (flags_reg.lss_config)
            green_co = work_gr_reg[coled_pkg::BIT_FLICKER];
        else if (flags_reg.firmware_download)
            green_co = work_gr_reg[coled_pkg::BIT_FLASH3];
        else if (flags_reg.node_state == coled_pkg::NODE_STOPPED)
            green_co = work_gr_reg[coled_pkg::BIT_FLASH1];
        else if (flags_reg.node_state == coled_pkg::NODE_PREOP)
            green_co = work_gr_reg[coled_pkg::BIT_BLINK];
        else if (flags_reg.node_state == coled_pkg::NODE_OPER)
            green_co = 1'b1;
        else
            green_co = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            rem_reg        <= '0;
            time_next_reg  <= coled_pkg::REM_W'(TICK_US);
            quarter_reg    <= '0;
            red_bits_reg   <= '0;
            green_bits_reg <= '0;
            tick_seen_reg  <= 1'b0;
            for (int i = 0; i < coled_pkg::FLASH_NUM; i++)
            begin
                flash_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                acc_reg       <= coled_pkg::ACC_W'(rem_reg) + coled_pkg::ACC_W'(elapsed_us);
                tick_seen_reg <= 1'b0;
            end
            else if (cmd.tick)
            begin
                acc_reg       <= acc_reg - coled_pkg::ACC_W'(TICK_US);
                quarter_reg   <= quarter_reg + 2'd1;
                tick_seen_reg <= 1'b1;
                for (int i = 0; i < coled_pkg::FLASH_NUM; i++)
                begin
                    flash_cnt_reg[i] <= flash_cnt_next[i];
                end
            end
            if (cmd.commit)
            begin
                rem_reg       <= acc_reg[coled_pkg::REM_W-1:0];
                time_next_reg <= coled_pkg::REM_W'(TICK_US) - acc_reg[coled_pkg::REM_W-1:0];
                if (tick_seen_reg)
                begin
                    red_bits_reg   <= work_rd_reg | (coled_pkg::PAT_W'(red_co)
                                                     << coled_pkg::BIT_LED);
                    green_bits_reg <= work_gr_reg | (coled_pkg::PAT_W'(green_co)
                                                     << coled_pkg::BIT_LED);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            flags_reg <= flags_in;
        if (cmd.tick)
        begin
            work_rd_reg <= tick_rd;
            work_gr_reg <= tick_gr;
        end
    end

    assign red_pattern     = red_bits_reg;
    assign green_pattern   = green_bits_reg;
    assign time_to_next_us = time_next_reg;

    `CO_ASSERT_IMP(a_rem_range, clk, rst_n, 1'b1,
                   (rem_reg < coled_pkg::REM_W'(TICK_US)), "remainder out of range")
    `CO_ASSERT_IMP(a_commit_settled, clk, rst_n, cmd.commit, !status.tick_due,
                   "commit with a tick still due")
    `CO_ASSERT_NXT(a_quarter_step, clk, rst_n, cmd.tick,
                   (quarter_reg == $past(quarter_reg) + 2'd1), "quarter count skipped")

endmodule

[sv/coled_ctrl.sv]
`include "canopen_led_indicator_defines.svh"

module coled_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  coled_pkg::status_t status,
    output coled_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_TICK   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                if (status.tick_due)
                    cmd.tick = 1'b1;
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // the output slot must be free before the stored bitmaps move
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `CO_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, (!out_valid_reg || out_ready),
                   "result overwritten while stalled")
    `CO_ASSERT_NXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_reg,
                   "committed result not presented")
    `CO_ASSERT_IMP(a_tick_due, clk, rst_n, cmd.tick, status.tick_due,
                   "tick without a whole period")

endmodule

[sv/canopen_led_indicator.sv]
// canopen indicator led generator, error (red) and run (green) leds
// input request: in_valid/in_ready with elapsed_us, node_state and the
// fault and mode flags; taken whenever the block is idle
// result: out_valid/out_ready with both pattern bitmaps, both led levels
// and time_to_next_us, held in the output registers until taken
// an item with N = floor((remainder + elapsed_us) / TICK_US) whole periods
// runs from accept to the next accept through a load step, a pass through
// the shared tick step for each of the N periods of TICK_US, a settling
// step and a commit step; the result is registered at the commit step
// a new request is accepted while the previous result still waits
// if the receiver stalls, the finished item waits in the commit state and
// the stored bitmaps stay as shown; no further request is accepted then
// reset clears the remainder, the quarter and flash counters and both
// bitmaps, and leaves no result pending
module canopen_led_indicator #(
    parameter int unsigned TICK_US = coled_pkg::TICK_US_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [coled_pkg::ELAPSED_W-1:0]     elapsed_us,
    input  logic [coled_pkg::NSTATE_W-1:0]      node_state,
    input  logic                                lss_config,
    input  logic                                bus_off,
    input  logic                                bus_warning,
    input  logic                                rpdo_error,
    input  logic                                sync_error,
    input  logic                                heartbeat_error,
    input  logic                                other_error,
    input  logic                                firmware_download,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [coled_pkg::PAT_W-1:0]         red_pattern,
    output logic [coled_pkg::PAT_W-1:0]         green_pattern,
    output logic                                red_led,
    output logic                                green_led,
    output logic [coled_pkg::REM_W-1:0]         time_to_next_us
);

    coled_pkg::flags_t  flags;
    coled_pkg::cmd_t    cmd;
    coled_pkg::status_t status;

    assign flags.node_state        = node_state;
    assign flags.lss_config        = lss_config;
    assign flags.bus_off           = bus_off;
    assign flags.bus_warning       = bus_warning;
    assign flags.rpdo_error        = rpdo_error;
    assign flags.sync_error        = sync_error;
    assign flags.heartbeat_error   = heartbeat_error;
    assign flags.other_error       = other_error;
    assign flags.firmware_download = firmware_download;

    coled_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    coled_dp #(
        .TICK_US (TICK_US)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .elapsed_us      (elapsed_us),
        .flags_in        (flags),
        .cmd             (cmd),
        .status          (status),
        .red_pattern     (red_pattern),
        .green_pattern   (green_pattern),
        .time_to_next_us (time_to_next_us)
    );

    assign red_led   = red_pattern[coled_pkg::BIT_LED];
    assign green_led = green_pattern[coled_pkg::BIT_LED];

endmodule
